/* design/wcbd_pkg.sv */
// shared types and constants of the channel block decoder
package wcbd_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int SLOT_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [15:0]        channel_id;
    logic signed [31:0] sample;
    logic [11:0]        sample_index;
    logic [11:0]        sample_count;
    logic               last_of_channel;
    logic               bad_header;
  } result_t;

  // results produced by one input item, r0 first
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

/* design/wcbd_core.sv */
// block parser: header, first sample, difference decode and skip of bad blocks
module wcbd_core import wcbd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  output push_t      push
);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_FIRST  = 2'd1,
    PH_DIFF   = 2'd2,
    PH_SKIP   = 2'd3
  } phase_t;

  localparam logic [3:0] SZ_NIBBLE = 4'd0;
  localparam logic [3:0] SZ_BYTE1  = 4'd1;
  localparam logic [3:0] SZ_BYTE2  = 4'd2;
  localparam logic [3:0] SZ_BYTE3  = 4'd3;
  localparam logic [3:0] SZ_MAX    = 4'd4;

  phase_t      phase, phase_next;
  logic [1:0]  byte_position, byte_position_next;
  logic [31:0] assembly, assembly_next;
  logic [15:0] channel_code, channel_code_next;
  logic [3:0]  size_code, size_code_next;
  logic [11:0] announced_count, announced_count_next;
  logic [11:0] current_index, current_index_next;
  logic [31:0] accumulator, accumulator_next;
  logic [15:0] skip_counter, skip_counter_next;

  logic [31:0] asm_shift;
  logic [15:0] hdr_code;
  logic [3:0]  hdr_size;
  logic [11:0] hdr_count;
  logic [15:0] skip_prod;
  logic [15:0] skip_dec;
  logic [4:0]  nib_sum;
  logic [31:0] acc_hi, acc_pair, acc_bytes, diff_bytes;
  logic [11:0] index_plus;
  logic        last_hi, last_lo, last_bytes;
  logic [2:0]  pos_plus;

  assign asm_shift  = {assembly[23:0], data_byte};
  assign hdr_code   = asm_shift[31:16];
  assign hdr_size   = asm_shift[15:12];
  assign hdr_count  = asm_shift[11:0];
  assign skip_prod  = {12'd0, hdr_size} * {4'd0, hdr_count - 12'd1};
  assign skip_dec   = (skip_counter != 16'd0) ? skip_counter - 16'd1 : 16'd0;

  // nibble mode: both samples from parallel adds
  assign nib_sum    = {data_byte[7], data_byte[7:4]} + {data_byte[3], data_byte[3:0]};
  assign acc_hi     = accumulator + {{28{data_byte[7]}}, data_byte[7:4]};
  assign acc_pair   = accumulator + {{27{nib_sum[4]}}, nib_sum};
  assign index_plus = current_index + 12'd1;
  assign last_hi    = (current_index == announced_count - 12'd1);
  assign last_lo    = (index_plus == announced_count - 12'd1);

  assign pos_plus   = {1'b0, byte_position} + 3'd1;

  always_comb begin
    unique case (size_code)
      SZ_BYTE1: diff_bytes = {{24{asm_shift[7]}}, asm_shift[7:0]};
      SZ_BYTE2: diff_bytes = {{16{asm_shift[15]}}, asm_shift[15:0]};
      SZ_BYTE3: diff_bytes = {{8{asm_shift[23]}}, asm_shift[23:0]};
      default:  diff_bytes = asm_shift;
    endcase
  end

  assign acc_bytes  = accumulator + diff_bytes;
  assign last_bytes = last_hi;

  always_comb begin
    phase_next           = phase;
    byte_position_next   = byte_position;
    assembly_next        = assembly;
    channel_code_next    = channel_code;
    size_code_next       = size_code;
    announced_count_next = announced_count;
    current_index_next   = current_index;
    accumulator_next     = accumulator;
    skip_counter_next    = skip_counter;
    push                 = '0;
    push.r0.channel_id   = channel_code;
    push.r0.sample_count = announced_count;
    push.r1.channel_id   = channel_code;
    push.r1.sample_count = announced_count;

    unique case (phase)
      PH_SKIP: begin
        skip_counter_next = skip_dec;
        if (skip_dec == 16'd0) begin
          phase_next = PH_HEADER;
        end
      end
      PH_HEADER, PH_FIRST: begin
        assembly_next = asm_shift;
        if (byte_position != 2'd3) begin
          byte_position_next = byte_position + 2'd1;
        end else begin
          byte_position_next = 2'd0;
          assembly_next      = 32'd0;
          if (phase == PH_HEADER) begin
            channel_code_next    = hdr_code;
            size_code_next       = hdr_size;
            announced_count_next = hdr_count;
            if (hdr_size > SZ_MAX || hdr_count == 12'd0) begin
              skip_counter_next = (hdr_count == 12'd0) ? 16'd4 : skip_prod + 16'd4;
              phase_next        = PH_SKIP;
              push.n                  = 2'd1;
              push.r0.channel_id      = hdr_code;
              push.r0.sample_count    = hdr_count;
              push.r0.last_of_channel = 1'b1;
              push.r0.bad_header      = 1'b1;
            end else begin
              phase_next = PH_FIRST;
            end
          end else begin
            accumulator_next = asm_shift;
            push.n           = 2'd1;
            push.r0.sample   = asm_shift;
            if (announced_count == 12'd1) begin
              phase_next              = PH_HEADER;
              push.r0.last_of_channel = 1'b1;
            end else begin
              phase_next         = PH_DIFF;
              current_index_next = 12'd1;
            end
          end
        end
      end
      PH_DIFF: begin
        if (size_code == SZ_NIBBLE) begin
          push.r0.sample          = acc_hi;
          push.r0.sample_index    = current_index;
          push.r0.last_of_channel = last_hi;
          if (last_hi) begin
            push.n           = 2'd1;
            accumulator_next = acc_hi;
            phase_next       = PH_HEADER;
          end else begin
            push.n                  = 2'd2;
            push.r1.sample          = acc_pair;
            push.r1.sample_index    = index_plus;
            push.r1.last_of_channel = last_lo;
            accumulator_next        = acc_pair;
            if (last_lo) begin
              current_index_next = index_plus;
              phase_next         = PH_HEADER;
            end else begin
              current_index_next = index_plus + 12'd1;
            end
          end
        end else begin
          assembly_next = asm_shift;
          if ({1'b0, pos_plus} < size_code) begin
            byte_position_next = pos_plus[1:0];
          end else begin
            byte_position_next      = 2'd0;
            assembly_next           = 32'd0;
            accumulator_next        = acc_bytes;
            push.n                  = 2'd1;
            push.r0.sample          = acc_bytes;
            push.r0.sample_index    = current_index;
            push.r0.last_of_channel = last_bytes;
            if (last_bytes) begin
              phase_next = PH_HEADER;
            end else begin
              current_index_next = index_plus;
            end
          end
        end
      end
    endcase

    if (!accept) begin
      push.n = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      byte_position   <= 2'd0;
      assembly        <= 32'd0;
      channel_code    <= 16'd0;
      size_code       <= 4'd0;
      announced_count <= 12'd0;
      current_index   <= 12'd0;
      accumulator     <= 32'd0;
      skip_counter    <= 16'd0;
    end else if (accept) begin
      phase           <= phase_next;
      byte_position   <= byte_position_next;
      assembly        <= assembly_next;
      channel_code    <= channel_code_next;
      size_code       <= size_code_next;
      announced_count <= announced_count_next;
      current_index   <= current_index_next;
      accumulator     <= accumulator_next;
      skip_counter    <= skip_counter_next;
    end
  end

endmodule

/* design/wcbd_out_queue.sv */
// small result queue taking up to two results per cycle and giving one
module wcbd_out_queue import wcbd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  push_t              push,
  input  logic               pop,
  output result_t            head,
  output logic [LEVEL_W-1:0] level
);

  result_t            q [QUEUE_DEPTH];
  result_t            q_next [QUEUE_DEPTH];
  logic [LEVEL_W-1:0] level_next;
  logic [LEVEL_W-1:0] base;
  logic [LEVEL_W-1:0] base_plus;

  always_comb begin
    q_next = q;
    base   = level;
    if (pop) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        q_next[i] = q[i + 1];
      end
      base = level - LEVEL_W'(1);
    end
    base_plus = base + LEVEL_W'(1);
    if (push.n != 2'd0) begin
      q_next[base[SLOT_W-1:0]] = push.r0;
    end
    if (push.n == 2'd2) begin
      q_next[base_plus[SLOT_W-1:0]] = push.r1;
    end
    level_next = base + LEVEL_W'(push.n);
  end

  always_ff @(posedge clk) begin
    q <= q_next;
    if (rst) begin
      level <= '0;
    end else begin
      level <= level_next;
    end
  end

  assign head = q[0];

endmodule

/* design/win_channel_block_decoder.sv */
// Channel block decoder: takes one stream byte per cycle and returns decoded samples.
// A byte is taken in the cycle it is offered while the result queue has room for two
// results. Header, first-sample and byte-mode difference bytes each give at most one
// sample. In nibble mode a byte gives up to two samples, so the output port, which
// sends one sample per cycle, limits how fast such bytes are taken. The four-entry
// result queue lets a byte be taken while earlier samples still wait.
// A bad header gives one result flagged on tuser and its block's bytes are dropped.
module win_channel_block_decoder import wcbd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // channel_id, sample, sample_index, sample_count
  output logic        m_tlast,   // last_of_channel
  output logic        m_tuser    // bad_header
);

  logic               accept;
  logic               pop;
  push_t              push;
  result_t            head;
  logic [LEVEL_W-1:0] level;

  assign s_tready = (level <= LEVEL_W'(QUEUE_DEPTH - 2));
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = (level != '0);
  assign pop      = m_tvalid && m_tready;

  wcbd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (s_tdata),
    .push      (push)
  );

  wcbd_out_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .level (level)
  );

  assign m_tdata = {head.sample_count, head.sample_index, head.sample, head.channel_id};
  assign m_tlast = head.last_of_channel;
  assign m_tuser = head.bad_header;

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= LEVEL_W'(QUEUE_DEPTH))
    else $error("result queue overflow");

  a_push_seen: assert property (@(posedge clk) disable iff (rst)
    (push.n != 2'd0) |=> m_tvalid)
    else $error("accepted result not presented");

  a_bad_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tlast)
    else $error("bad header result without last flag");

  a_push_needs_accept: assert property (@(posedge clk) disable iff (rst)
    (push.n != 2'd0) |-> accept)
    else $error("result pushed without an accepted item");

endmodule
